FILE: design/mpd_pkg.sv
// Shared types and constants of the magnetic presence detector.
`default_nettype none

package mpd_pkg;

    // Weight width of both moving averages (Q0.16)
    localparam int ALPHA_BITS = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_PRESENT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MS      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASELINE_ALPHA = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_ALPHA   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_THRESHOLD   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_THRESHOLD  = 3'd5;

    // Register reset values
    localparam logic        RST_SENSOR_PRESENT = 1'b1;
    localparam logic [15:0] RST_WINDOW_MS      = 16'd10000;
    localparam logic [15:0] RST_BASELINE_ALPHA = 16'd3277;
    localparam logic [15:0] RST_OUTPUT_ALPHA   = 16'd32768;
    localparam logic [16:0] RST_ON_THRESHOLD   = 17'd380;
    localparam logic [16:0] RST_OFF_THRESHOLD  = 17'd360;

    // Phase codes
    localparam logic [1:0] PH_FAIL  = 2'd0;
    localparam logic [1:0] PH_BUILD = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;

    // Presence codes
    localparam logic [2:0] PC_NONE   = 3'd0;
    localparam logic [2:0] PC_RED    = 3'd1;
    localparam logic [2:0] PC_BLUE   = 3'd2;
    localparam logic [2:0] PC_BOTH   = 3'd3;
    localparam logic [2:0] PC_MAGNET = 3'd4;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic               read_ok;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic               blue_switch;
        logic               red_switch;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [2:0]  presence_code;
        logic        any_present;
        logic        magnet_present;
        logic [16:0] filtered_magnitude;
    } out_item_t;

endpackage

`default_nettype wire

FILE: design/magnetic_presence_detector.sv
// Magnetic presence detector top level: baseline EMA, serial magnitude, hysteresis.
//
// Usage:
//  - sample channel (sample_valid / sample_stall / sample): one magnetometer
//    reading with time, read status and the two debounced switches. The block
//    raises sample_stall while an item is being worked on; one item at a time.
//  - result channel (result_valid / result_stall / result): one result per
//    sample, held in an output register until the receiver drops result_stall.
//    A new sample is taken while an earlier result still waits there.
//  - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//    writes, always ready; write only while the block is idle.
// Path through the sequencer, from accept to the output register:
//  - sensor absent, failed read, first baseline sample: straight to finish
//  - baseline averaging: three passes of the serial alpha multiply
//  - running: set by the bit-serial sum of squares, the one-bit-per-cycle
//    square root and the 16-step alpha multiply, run in turn by one
//    sequencer (the first magnitude skips the alpha multiply)
// The next sample transfer can land on the edge where the result can first
// move, while the receiver keeps up.
// A stalled receiver holds the finished item in its last step; nothing is lost.
// Reset (rst_n low, asynchronous) clears all history and restores the
// register defaults; no clearing pass is needed.
`default_nettype none

module magnetic_presence_detector
    import mpd_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    sample_valid,
    output logic                   sample_stall,
    input  in_item_t               sample,
    output logic                   result_valid,
    input  wire                    result_stall,
    output out_item_t              result,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [CFG_INDEX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data
);

    // Widths: baseline signed Q16.F, magnitude unsigned Q17.F
    localparam int BW = 16 + FRACTION_BITS;   // baseline
    localparam int MW = 17 + FRACTION_BITS;   // magnitude / |deviation|
    localparam int DW = MW + 1;               // signed EMA difference
    localparam int AW = DW + ALPHA_BITS;      // alpha product
    localparam int SW = 2 * MW;               // sum of squares
    localparam int RW = MW + 2;               // root remainder
    localparam int CW = $clog2(MW);

    localparam logic [AW-1:0] ROUND_HALF = AW'(1) << (ALPHA_BITS - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SQUARE   = 3'd1;
    localparam logic [2:0] ST_ROOT     = 3'd2;
    localparam logic [2:0] ST_EMA_LOAD = 3'd3;
    localparam logic [2:0] ST_EMA_MUL  = 3'd4;
    localparam logic [2:0] ST_EMA_WB   = 3'd5;
    localparam logic [2:0] ST_HYST     = 3'd6;
    localparam logic [2:0] ST_FINISH   = 3'd7;

    // Configuration registers
    logic        sensor_present_reg;
    logic [15:0] window_reg;
    logic [15:0] balpha_reg;
    logic [15:0] oalpha_reg;
    logic [16:0] on_reg;
    logic [16:0] off_reg;

    // Detector history
    logic                 base_loaded_reg, base_loaded_next;
    logic                 base_finished_reg, base_finished_next;
    logic signed [BW-1:0] base_reg [3];
    logic signed [BW-1:0] base_next [3];
    logic                 smooth_loaded_reg, smooth_loaded_next;
    logic [MW-1:0]        smoothed_reg, smoothed_next;
    logic                 flag_reg, flag_next;

    // Sequencer and datapath
    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [1:0]           axis_reg, axis_next;
    logic                 ema_base_reg, ema_base_next;
    logic [1:0]           phase_reg, phase_next;
    logic                 blue_reg, blue_next;
    logic                 red_reg, red_next;
    logic signed [15:0]   samp_reg [3];
    logic signed [15:0]   samp_next [3];
    logic [MW-1:0]        mcand_reg [3];
    logic [MW-1:0]        mcand_next [3];
    logic [MW-1:0]        mplier_reg [3];
    logic [MW-1:0]        mplier_next [3];
    logic [SW-1:0]        acc_reg, acc_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [MW-1:0]        root_reg, root_next;
    logic [DW-1:0]        diff_reg, diff_next;
    logic [ALPHA_BITS-1:0] alpha_reg, alpha_next;
    logic [AW-1:0]        prod_reg, prod_next;

    // Output register
    logic                 result_valid_reg, result_valid_next;
    out_item_t            result_reg, result_next;

    // Helpers
    logic signed [15:0]   mag_in [3];
    logic [MW-1:0]        dev [3];
    logic [MW-1:0]        abs_dev [3];
    logic [SW-1:0]        sq_sum;
    logic [RW+1:0]        rem_sh;
    logic [RW+1:0]        trial;
    logic                 root_ge;
    logic [RW+1:0]        rem_new;
    logic signed [15:0]   samp_sel;
    logic signed [BW-1:0] base_sel;
    logic [DW-1:0]        base_sel_ext;
    logic [AW-1:0]        prod_rnd;
    logic [DW-1:0]        ema_step;
    logic [DW-1:0]        ema_sum_base;
    logic [DW-1:0]        ema_sum_mag;
    logic [16:0]          mag_int;
    logic                 frac_zero;
    logic                 accept;
    logic                 out_free;
    logic [2:0]           code;

    assign mag_in[0] = sample.mag_x;
    assign mag_in[1] = sample.mag_y;
    assign mag_in[2] = sample.mag_z;

    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && (state_reg == ST_IDLE);
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // Deviation from the baseline, taken at accept for the running path
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dev[i] = {mag_in[i][15], mag_in[i], {FRACTION_BITS{1'b0}}}
                   - {base_reg[i][BW-1], base_reg[i]};
            abs_dev[i] = dev[i][MW-1] ? (~dev[i] + MW'(1)) : dev[i];
        end
    end

    // Bit-serial sum of squares, MSB first
    assign sq_sum = {acc_reg[SW-2:0], 1'b0}
                  + (mplier_reg[0][MW-1] ? {{MW{1'b0}}, mcand_reg[0]} : '0)
                  + (mplier_reg[1][MW-1] ? {{MW{1'b0}}, mcand_reg[1]} : '0)
                  + (mplier_reg[2][MW-1] ? {{MW{1'b0}}, mcand_reg[2]} : '0);

    // Restoring square root, one result bit per cycle
    assign rem_sh  = {rem_reg, acc_reg[SW-1:SW-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign root_ge = (rem_sh >= trial);
    assign rem_new = root_ge ? (rem_sh - trial) : rem_sh;

    // Moving-average update: cur + floor((alpha * diff + half) / 2^16)
    assign samp_sel     = samp_reg[axis_reg];
    assign base_sel     = base_reg[axis_reg];
    assign base_sel_ext = {{2{base_sel[BW-1]}}, base_sel};
    assign prod_rnd     = prod_reg + ROUND_HALF;
    assign ema_step     = prod_rnd[AW-1:ALPHA_BITS];
    assign ema_sum_base = base_sel_ext + ema_step;
    assign ema_sum_mag  = {1'b0, smoothed_reg} + ema_step;

    assign mag_int   = smoothed_reg[MW-1:FRACTION_BITS];
    assign frac_zero = (smoothed_reg[FRACTION_BITS-1:0] == '0);

    always_comb
    begin
        if (blue_reg && red_reg)
            code = PC_BOTH;
        else if (blue_reg)
            code = PC_BLUE;
        else if (red_reg)
            code = PC_RED;
        else if (flag_reg)
            code = PC_MAGNET;
        else
            code = PC_NONE;
    end

    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        axis_next          = axis_reg;
        ema_base_next      = ema_base_reg;
        phase_next         = phase_reg;
        blue_next          = blue_reg;
        red_next           = red_reg;
        base_loaded_next   = base_loaded_reg;
        base_finished_next = base_finished_reg;
        smooth_loaded_next = smooth_loaded_reg;
        smoothed_next      = smoothed_reg;
        flag_next          = flag_reg;
        acc_next           = acc_reg;
        rem_next           = rem_reg;
        root_next          = root_reg;
        diff_next          = diff_reg;
        alpha_next         = alpha_reg;
        prod_next          = prod_reg;
        result_next        = result_reg;
        result_valid_next  = result_valid_reg && result_stall;
        for (int i = 0; i < 3; i++)
        begin
            base_next[i]   = base_reg[i];
            samp_next[i]   = samp_reg[i];
            mcand_next[i]  = mcand_reg[i];
            mplier_next[i] = mplier_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    blue_next = sample.blue_switch;
                    red_next  = sample.red_switch;
                    for (int i = 0; i < 3; i++)
                        samp_next[i] = mag_in[i];
                    state_next = ST_FINISH;
                    if (!sensor_present_reg)
                    begin
                        flag_next  = 1'b0;
                        phase_next = PH_RUN;
                    end
                    else if (!sample.read_ok)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (!base_finished_reg)
                    begin
                        phase_next       = PH_BUILD;
                        base_loaded_next = 1'b1;
                        if (sample.time_ms >= {16'd0, window_reg})
                            base_finished_next = 1'b1;
                        if (!base_loaded_reg)
                        begin
                            for (int i = 0; i < 3; i++)
                                base_next[i] = {mag_in[i], {FRACTION_BITS{1'b0}}};
                        end
                        else
                        begin
                            axis_next     = 2'd0;
                            ema_base_next = 1'b1;
                            state_next    = ST_EMA_LOAD;
                        end
                    end
                    else
                    begin
                        phase_next = PH_RUN;
                        for (int i = 0; i < 3; i++)
                        begin
                            mcand_next[i]  = abs_dev[i];
                            mplier_next[i] = abs_dev[i];
                        end
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_SQUARE;
                    end
                end
            end

            ST_SQUARE:
            begin
                acc_next = sq_sum;
                for (int i = 0; i < 3; i++)
                    mplier_next[i] = {mplier_reg[i][MW-2:0], 1'b0};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MW - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = ST_ROOT;
                end
            end

            ST_ROOT:
            begin
                acc_next  = {acc_reg[SW-3:0], 2'b00};
                rem_next  = rem_new[RW-1:0];
                root_next = {root_reg[MW-2:0], root_ge};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MW - 1))
                begin
                    if (smooth_loaded_reg)
                    begin
                        ema_base_next = 1'b0;
                        state_next    = ST_EMA_LOAD;
                    end
                    else
                    begin
                        smoothed_next      = {root_reg[MW-2:0], root_ge};
                        smooth_loaded_next = 1'b1;
                        state_next         = ST_HYST;
                    end
                end
            end

            ST_EMA_LOAD:
            begin
                if (ema_base_reg)
                begin
                    diff_next  = {{2{samp_sel[15]}}, samp_sel, {FRACTION_BITS{1'b0}}}
                               - base_sel_ext;
                    alpha_next = balpha_reg;
                end
                else
                begin
                    diff_next  = {1'b0, root_reg} - {1'b0, smoothed_reg};
                    alpha_next = oalpha_reg;
                end
                prod_next  = '0;
                cnt_next   = '0;
                state_next = ST_EMA_MUL;
            end

            ST_EMA_MUL:
            begin
                // Horner over alpha bits, MSB first; two's complement wraps cleanly
                prod_next = {prod_reg[AW-2:0], 1'b0}
                          + (alpha_reg[ALPHA_BITS-1]
                             ? {{ALPHA_BITS{diff_reg[DW-1]}}, diff_reg} : '0);
                alpha_next = {alpha_reg[ALPHA_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(ALPHA_BITS - 1))
                    state_next = ST_EMA_WB;
            end

            ST_EMA_WB:
            begin
                if (ema_base_reg)
                begin
                    base_next[axis_reg] = ema_sum_base[BW-1:0];
                    if (axis_reg == 2'd2)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_EMA_LOAD;
                    end
                end
                else
                begin
                    smoothed_next = ema_sum_mag[MW-1:0];
                    state_next    = ST_HYST;
                end
            end

            ST_HYST:
            begin
                if (!flag_reg)
                begin
                    if (mag_int >= on_reg)
                        flag_next = 1'b1;
                end
                else if ((mag_int < off_reg) || ((mag_int == off_reg) && frac_zero))
                begin
                    flag_next = 1'b0;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    result_next.phase              = phase_reg;
                    result_next.presence_code      = code;
                    result_next.any_present        = flag_reg || blue_reg || red_reg;
                    result_next.magnet_present     = flag_reg;
                    result_next.filtered_magnitude = mag_int;
                    result_valid_next              = 1'b1;
                    state_next                     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            base_loaded_reg   <= 1'b0;
            base_finished_reg <= 1'b0;
            smooth_loaded_reg <= 1'b0;
            smoothed_reg      <= '0;
            flag_reg          <= 1'b0;
            result_valid_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
                base_reg[i] <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            base_loaded_reg   <= base_loaded_next;
            base_finished_reg <= base_finished_next;
            smooth_loaded_reg <= smooth_loaded_next;
            smoothed_reg      <= smoothed_next;
            flag_reg          <= flag_next;
            result_valid_reg  <= result_valid_next;
            for (int i = 0; i < 3; i++)
                base_reg[i] <= base_next[i];
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        axis_reg     <= axis_next;
        ema_base_reg <= ema_base_next;
        phase_reg    <= phase_next;
        blue_reg     <= blue_next;
        red_reg      <= red_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        diff_reg     <= diff_next;
        alpha_reg    <= alpha_next;
        prod_reg     <= prod_next;
        result_reg   <= result_next;
        for (int i = 0; i < 3; i++)
        begin
            samp_reg[i]   <= samp_next[i];
            mcand_reg[i]  <= mcand_next[i];
            mplier_reg[i] <= mplier_next[i];
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_present_reg <= RST_SENSOR_PRESENT;
            window_reg         <= RST_WINDOW_MS;
            balpha_reg         <= RST_BASELINE_ALPHA;
            oalpha_reg         <= RST_OUTPUT_ALPHA;
            on_reg             <= RST_ON_THRESHOLD;
            off_reg            <= RST_OFF_THRESHOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SENSOR_PRESENT: sensor_present_reg <= cfg_data[0];
                REG_WINDOW_MS:      window_reg         <= cfg_data[15:0];
                REG_BASELINE_ALPHA: balpha_reg         <= cfg_data[15:0];
                REG_OUTPUT_ALPHA:   oalpha_reg         <= cfg_data[15:0];
                REG_ON_THRESHOLD:   on_reg             <= cfg_data;
                REG_OFF_THRESHOLD:  off_reg            <= cfg_data;
                default:            ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // The window can only close once a baseline has been loaded
    a_finished_needs_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        base_finished_reg |-> base_loaded_reg)
        else $error("baseline finished without a loaded baseline");

    // A finished item with a free output register is presented next cycle
    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && !result_valid_reg |=> result_valid_reg)
        else $error("finished item not presented");

    // No presence of any kind means the code reports none
    a_code_none: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.any_present |->
            (result_reg.presence_code == PC_NONE))
        else $error("presence code without presence");

    // Smoothing only runs after the baseline window closed
    a_smooth_after_base: assert property (@(posedge clk) disable iff (!rst_n)
        smooth_loaded_reg |-> base_finished_reg)
        else $error("smoothing loaded before baseline finished");
`endif

endmodule

`default_nettype wire
